### design/dds_pkg.sv
// Shared types and constants for the DDS waveform oscillator.
`timescale 1ns / 1ps

package dds_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_PHASE_INC = 2'd1;
  localparam logic [1:0] CFG_AMPLITUDE = 2'd2;
  localparam logic [1:0] CFG_WAVEFORM  = 2'd3;

  localparam int CFG_DATA_W = 32;
  localparam int PHASE_W    = 32;
  localparam int SAMPLE_W   = 16;
  localparam int AMP_W      = 16;
  // gain held one bit wider so that full scale 32768 fits as a positive value
  localparam int GAIN_W     = AMP_W + 1;

  localparam logic [GAIN_W-1:0]          GAIN_FULL  = 17'd32768;
  localparam logic signed [SAMPLE_W-1:0] SQUARE_POS = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SQUARE_NEG = -16'sd32767;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_t;

  // Word leaving the phase stage towards the scaler
  typedef struct packed {
    logic                       valid;
    logic                       en;
    logic                       use_rom;
    logic signed [SAMPLE_W-1:0] alt;
    logic [GAIN_W-1:0]          gain;
  } dds_s1_t;

endpackage

### design/dds_sine_rom.sv
// One-period sine table with a registered synchronous read port.
`timescale 1ns / 1ps

module dds_sine_rom #(
  parameter int ADDR_W = 8
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [ADDR_W-1:0]                    rd_addr,
  output logic signed [dds_pkg::SAMPLE_W-1:0]  rd_data
);

  localparam int RomLen  = 1 << ADDR_W;
  localparam int QtrBits = ADDR_W - 2;
  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;
  localparam logic [63:0] OneQ30   = 64'd1073741824;
  localparam logic [63:0] HalfQ30  = 64'd536870912;
  localparam logic [63:0] MaxMag   = 64'd32767;

  typedef logic signed [dds_pkg::SAMPLE_W-1:0] rom_t [RomLen];

  // two powers of x per Taylor term, both rescaled from Q2.30
  function automatic logic [63:0] pow_step(logic [63:0] term, logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  function automatic logic [15:0] quarter_value(logic [63:0] k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        mag;
    x    = (TwoPiQ30 * k) >> ADDR_W;
    sum  = $signed(x);
    term = x;
    term = pow_step(term, x) / 6;   sum = sum - $signed(term);
    term = pow_step(term, x) / 20;  sum = sum + $signed(term);
    term = pow_step(term, x) / 42;  sum = sum - $signed(term);
    term = pow_step(term, x) / 72;  sum = sum + $signed(term);
    term = pow_step(term, x) / 110; sum = sum - $signed(term);
    term = pow_step(term, x) / 156; sum = sum + $signed(term);
    term = pow_step(term, x) / 210; sum = sum - $signed(term);
    term = pow_step(term, x) / 272; sum = sum + $signed(term);
    term = pow_step(term, x) / 342; sum = sum - $signed(term);
    term = pow_step(term, x) / 420; sum = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > $signed(OneQ30)) begin
      sum = $signed(OneQ30);
    end
    mag = ($unsigned(sum) * MaxMag + HalfQ30) >> 30;
    if (mag > MaxMag) begin
      mag = MaxMag;
    end
    return mag[15:0];
  endfunction

  // mirror the first quadrant over the whole period
  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] j;
    logic [63:0] q;
    logic [1:0]  quad;
    q = 64'(RomLen / 4);
    for (int i = 0; i < RomLen; i++) begin
      quad = 2'(i >> QtrBits);
      j    = 64'(i) & (q - 64'd1);
      unique case (quad)
        2'd0: tbl[i] = $signed(quarter_value(j));
        2'd1: tbl[i] = $signed(quarter_value(q - j));
        2'd2: tbl[i] = -$signed(quarter_value(j));
        default: tbl[i] = -$signed(quarter_value(q - j));
      endcase
    end
    return tbl;
  endfunction

  localparam rom_t SineTbl = build_rom();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= SineTbl[rd_addr];
    end
  end

endmodule

### design/dds_scale.sv
// Gain multiply, rounding and output register stage of the oscillator.
`timescale 1ns / 1ps

module dds_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  dds_pkg::dds_s1_t                    s1,
  input  logic signed [dds_pkg::SAMPLE_W-1:0] rom_data,
  output logic                                out_valid,
  output logic signed [dds_pkg::SAMPLE_W-1:0] out_sample
);

  localparam int ProdW = dds_pkg::SAMPLE_W + dds_pkg::GAIN_W + 1;
  localparam int ShW   = ProdW - 15;
  localparam logic signed [ProdW-1:0] RoundBias = ProdW'(16384);
  localparam logic signed [ShW-1:0]   SatHi     = ShW'(32767);
  localparam logic signed [ShW-1:0]   SatLo     = -ShW'(32768);

  logic                              s2_valid_r;
  logic                              s2_en_r;
  logic signed [ProdW-1:0]           s2_prod_r;
  logic signed [ProdW-1:0]           prod_nxt;
  logic signed [dds_pkg::SAMPLE_W-1:0] wave;
  logic signed [ProdW-1:0]           rounded;
  logic signed [ShW-1:0]             shifted;
  logic signed [dds_pkg::SAMPLE_W-1:0] sample_nxt;
  logic                              out_valid_r;
  logic signed [dds_pkg::SAMPLE_W-1:0] out_sample_r;

  always_comb begin
    wave     = s1.use_rom ? rom_data : s1.alt;
    prod_nxt = ProdW'(wave) * $signed({1'b0, s1.gain});
  end

  always_comb begin
    rounded = s2_prod_r + RoundBias;
    shifted = ShW'(rounded >>> 15);
    if (!s2_en_r) begin
      sample_nxt = '0;
    end else if (shifted > SatHi) begin
      sample_nxt = SatHi[dds_pkg::SAMPLE_W-1:0];
    end else if (shifted < SatLo) begin
      sample_nxt = SatLo[dds_pkg::SAMPLE_W-1:0];
    end else begin
      sample_nxt = shifted[dds_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r  <= s1.valid;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_en_r      <= s1.en;
      s2_prod_r    <= prod_nxt;
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

### design/dds_waveform_oscillator_core.sv
// Top level of the DDS oscillator: registers, phase accumulator and waveform select.
// Pipeline: a sample word reaches out_valid through three registers once its request
// is accepted (sine table read and phase stage, gain multiply, output).
// Throughput: one request per cycle; the 32-bit phase add is the only feedback loop.
// A held output word stalls the input; requests with sample_request low give no word.
// Reset (synchronous, rst_n low) clears the phase and pipeline; the table is fixed.
`timescale 1ns / 1ps

module dds_waveform_oscillator_core #(
  parameter int TABLE_LEN = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [dds_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_sample_request,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dds_pkg::SAMPLE_W-1:0]   out_sample
);

  localparam int RomBits = (TABLE_LEN <= 8) ? 3 : $clog2(TABLE_LEN);

  logic                              en_r;
  logic [dds_pkg::PHASE_W-1:0]       inc_r;
  logic [dds_pkg::AMP_W-1:0]         amp_r;
  dds_pkg::wave_t                    wave_r;
  logic [dds_pkg::PHASE_W-1:0]       phase_r;
  logic [dds_pkg::PHASE_W-1:0]       phase_nxt;
  logic                              advance;
  logic                              accept;
  logic                              step;
  logic [16:0]                       tri_t;
  logic signed [17:0]                tri_v;
  logic signed [dds_pkg::SAMPLE_W-1:0] alt_nxt;
  logic [dds_pkg::GAIN_W-1:0]        gain;
  dds_pkg::dds_s1_t                  s1_r;
  logic signed [dds_pkg::SAMPLE_W-1:0] rom_data;
  logic                              scale_valid;

  // the whole pipeline moves unless a finished word is held at the output
  assign advance  = !(scale_valid && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign step     = accept && in_sample_request && en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      inc_r  <= '0;
      amp_r  <= dds_pkg::GAIN_FULL[dds_pkg::AMP_W-1:0];
      wave_r <= dds_pkg::WAVE_SINE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dds_pkg::CFG_ENABLE:    en_r   <= cfg_data[0];
        dds_pkg::CFG_PHASE_INC: inc_r  <= cfg_data[dds_pkg::PHASE_W-1:0];
        dds_pkg::CFG_AMPLITUDE: amp_r  <= cfg_data[dds_pkg::AMP_W-1:0];
        default:                wave_r <= dds_pkg::wave_t'(cfg_data[1:0]);
      endcase
    end
  end

  assign phase_nxt = phase_r + inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  // non-table waveforms from the advanced phase
  always_comb begin
    tri_t = phase_nxt[31:15];
    if (tri_t < 17'd32768) begin
      tri_v = $signed({1'b0, tri_t});
    end else if (tri_t < 17'd98304) begin
      tri_v = 18'sd65536 - $signed({1'b0, tri_t});
      if (tri_v > 18'sd32767) begin
        tri_v = 18'sd32767;
      end
    end else begin
      tri_v = $signed({1'b0, tri_t}) - 18'sd131072;
    end
    unique case (wave_r)
      dds_pkg::WAVE_SQUARE:
        alt_nxt = phase_nxt[31] ? dds_pkg::SQUARE_POS : dds_pkg::SQUARE_NEG;
      dds_pkg::WAVE_TRIANGLE:
        alt_nxt = tri_v[dds_pkg::SAMPLE_W-1:0];
      dds_pkg::WAVE_SAW:
        alt_nxt = $signed({~phase_nxt[31], phase_nxt[30:16]});
      default:
        alt_nxt = '0;
    endcase
  end

  // clip the gain at full scale
  assign gain = ({1'b0, amp_r} > dds_pkg::GAIN_FULL) ? dds_pkg::GAIN_FULL : {1'b0, amp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (advance) begin
      s1_r.valid <= accept && in_sample_request;
    end
    if (advance) begin
      s1_r.en      <= en_r;
      s1_r.use_rom <= (wave_r == dds_pkg::WAVE_SINE);
      s1_r.alt     <= alt_nxt;
      s1_r.gain    <= gain;
    end
  end

  dds_sine_rom #(
    .ADDR_W (RomBits)
  ) u_rom (
    .clk     (clk),
    .rd_en   (advance),
    .rd_addr (phase_nxt[dds_pkg::PHASE_W-1 -: RomBits]),
    .rd_data (rom_data)
  );

  dds_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .s1         (s1_r),
    .rom_data   (rom_data),
    .out_valid  (scale_valid),
    .out_sample (out_sample)
  );

  assign out_valid = scale_valid;

`ifndef SYNTH
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r))
    else $error("phase moved without an enabled request");

  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> phase_r == $past(phase_r) + $past(inc_r))
    else $error("phase did not advance by the increment");

  a_req_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_sample_request |=> s1_r.valid)
    else $error("accepted request lost before the scaler");

  a_gain_clip: assert property (@(posedge clk) disable iff (!rst_n)
    s1_r.valid |-> s1_r.gain <= dds_pkg::GAIN_FULL)
    else $error("gain above full scale reached the multiplier");
`endif

endmodule
